FILE: sv/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared constants, codes and types of the buddy page allocator.
// ----------------------------------------------------------------------------
package bpa_pkg;

    // Sizes of the managed window and of the fields.
    localparam int NUM_PAGES    = 4096;
    localparam int ORDER_LEVELS = 11;
    localparam int PAGE_BITS    = 12;
    localparam int IDX_W        = $clog2(NUM_PAGES);
    localparam int LINK_W       = IDX_W + 1;
    localparam int ORD_W        = 4;
    localparam int FRAME_W      = 36;
    localparam int PFN_W        = FRAME_W + 1;
    localparam int ADDR_W       = 48;
    localparam int CNT_W        = 13;
    localparam int CFG_W        = 36;

    // The null link is the index one past the last page.
    localparam logic [LINK_W-1:0] NIL = LINK_W'(NUM_PAGES);

    // Operation kinds.
    localparam logic [1:0] KIND_ALLOC = 2'd0;
    localparam logic [1:0] KIND_FREE  = 2'd1;
    localparam logic [1:0] KIND_SEED  = 2'd2;

    // Status codes.
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_NO_BLOCK  = 2'd1;
    localparam logic [1:0] ST_BAD_ORDER = 2'd2;
    localparam logic [1:0] ST_OUTSIDE   = 2'd3;

    // Configuration register indexes.
    localparam logic CFG_BASE  = 1'b0;
    localparam logic CFG_COUNT = 1'b1;

    // Per-page descriptor: free-block head mark and block order.
    typedef struct packed {
        logic             is_free;
        logic [ORD_W-1:0] ord;
    } desc_t;

    // Datapath commands issued by the controller.
    typedef enum logic [4:0] {
        CMD_IDLE,
        CMD_CLEAR,
        CMD_LOAD,
        CMD_ST_ORDER,
        CMD_ST_NOBLK,
        CMD_ST_RANGE,
        CMD_A_START,
        CMD_A_NEXT,
        CMD_A_TAKE,
        CMD_A_UNLINK,
        CMD_A_HALF,
        CMD_A_GRANT,
        CMD_PUSH1,
        CMD_PUSH2,
        CMD_F_START,
        CMD_F_CHK,
        CMD_F_BUD,
        CMD_F_MERGE,
        CMD_F_HOME,
        CMD_S_INIT,
        CMD_S_TOP,
        CMD_S_DOWN,
        CMD_S_FREE,
        CMD_S_STEP,
        CMD_OUT
    } cmd_t;

    // Datapath status seen by the controller.
    typedef struct packed {
        logic [1:0] kind;
        logic       order_bad;
        logic       frame_in_win;
        logic       head_hit;
        logic       cur_top;
        logic       split_more;
        logic       half_ok;
        logic       chk_free;
        logic       can_merge;
        logic       bud_in_win;
        logic       bud_match;
        logic       seed_more;
        logic       ord_shrink;
        logic       clr_done;
    } dp_flags_t;

endpackage

FILE: sv/buddy_page_allocator.sv
// ----------------------------------------------------------------------------
// buddy_page_allocator
// Binary buddy page allocator with per-order free lists in descriptor memory.
// ----------------------------------------------------------------------------
// After reset the block clears its 4096-entry descriptor memory, one entry a
// cycle, and holds in_stall high while it does so; configuration writes are
// taken throughout. Items are then handled one at a time by a sequencer over
// descriptor and link memories with one write and one read port each. An alloc
// scans up from its order past the empty orders, then splits one level at a
// time; a free checks the buddy while it lies in the window and merges level
// by level, and stops early when the block is already free; a seed runs that
// free sequence, less its dispatch, once per aligned block it carves, after
// trying orders downward from the top for each block.
// The next item is taken while the last result still waits at the output.
// ----------------------------------------------------------------------------
module buddy_page_allocator import bpa_pkg::*; (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               cfg_we,
    input  logic               cfg_index,
    input  logic [CFG_W-1:0]   cfg_data,
    input  logic               in_valid,
    output logic               in_stall,
    input  logic [1:0]         kind,
    input  logic [ORD_W-1:0]   block_order,
    input  logic [FRAME_W-1:0] frame_number,
    input  logic [ADDR_W-1:0]  range_start_addr,
    input  logic [ADDR_W-1:0]  range_end_addr,
    output logic               out_valid,
    input  logic               out_stall,
    output logic [1:0]         status,
    output logic [FRAME_W-1:0] granted_frame,
    output logic [CNT_W-1:0]   pages_free
);

    cmd_t      cmd;
    dp_flags_t flags;

    // Sequencer.
    bpa_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .out_stall (out_stall),
        .flags     (flags),
        .cmd       (cmd),
        .in_stall  (in_stall),
        .out_valid (out_valid)
    );

    // Memories and arithmetic.
    bpa_datapath u_dp (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .cfg_we           (cfg_we),
        .cfg_index        (cfg_index),
        .cfg_data         (cfg_data),
        .kind             (kind),
        .block_order      (block_order),
        .frame_number     (frame_number),
        .range_start_addr (range_start_addr),
        .range_end_addr   (range_end_addr),
        .flags            (flags),
        .status           (status),
        .granted_frame    (granted_frame),
        .pages_free       (pages_free)
    );

endmodule

FILE: sv/bpa_datapath.sv
// ----------------------------------------------------------------------------
// bpa_datapath
// Descriptor memories, free-list heads, counters and working registers.
// ----------------------------------------------------------------------------
module bpa_datapath import bpa_pkg::*; (
    input  logic                clk,
    input  logic                rst_n,
    input  cmd_t                cmd,
    input  logic                cfg_we,
    input  logic                cfg_index,
    input  logic [CFG_W-1:0]    cfg_data,
    input  logic [1:0]          kind,
    input  logic [ORD_W-1:0]    block_order,
    input  logic [FRAME_W-1:0]  frame_number,
    input  logic [ADDR_W-1:0]   range_start_addr,
    input  logic [ADDR_W-1:0]   range_end_addr,
    output dp_flags_t           flags,
    output logic [1:0]          status,
    output logic [FRAME_W-1:0]  granted_frame,
    output logic [CNT_W-1:0]    pages_free
);

    // Descriptor and link memories.
    desc_t             desc_mem [NUM_PAGES];
    logic [LINK_W-1:0] next_mem [NUM_PAGES];
    logic [LINK_W-1:0] prev_mem [NUM_PAGES];
    desc_t             desc_q;
    logic [LINK_W-1:0] next_q;
    logic [LINK_W-1:0] prev_q;

    // State that reset clears.
    logic [FRAME_W-1:0] base_reg;
    logic [CNT_W-1:0]   pcount_reg;
    logic [LINK_W-1:0]  head_reg [ORDER_LEVELS];
    logic [CNT_W-1:0]   cnt_reg [ORDER_LEVELS];
    logic [CNT_W-1:0]   total_reg;
    logic [IDX_W:0]     clr_reg;

    // Working registers of the current item.
    logic [1:0]         kind_reg;
    logic [ORD_W-1:0]   ord_reg;
    logic [FRAME_W-1:0] frame_reg;
    logic [ADDR_W-1:0]  rstart_reg;
    logic [ADDR_W-1:0]  rend_reg;
    logic [ORD_W-1:0]   cur_reg;
    logic [IDX_W-1:0]   idx_reg;
    logic [IDX_W-1:0]   uidx_reg;
    logic [LINK_W-1:0]  h_reg;
    logic [PFN_W-1:0]   fpfn_reg;
    logic [PFN_W-1:0]   spfn_reg;
    logic [PFN_W-1:0]   limit_reg;
    logic [1:0]         status_reg;
    logic [FRAME_W-1:0] granted_reg;
    logic [1:0]         out_status_reg;
    logic [FRAME_W-1:0] out_granted_reg;
    logic [CNT_W-1:0]   out_free_reg;

    // Combinational helpers.
    logic [CNT_W-1:0]   win;
    logic [PFN_W-1:0]   base_ext;
    logic [PFN_W-1:0]   cur_bit;
    logic [PFN_W-1:0]   bud;
    logic [PFN_W-1:0]   bud_off;
    logic [PFN_W-1:0]   home_off;
    logic [LINK_W-1:0]  head_cur;
    logic [IDX_W+1:0]   half_sum;
    logic [CNT_W-1:0]   ord_bit;
    logic [PFN_W-1:0]   seed_bit;
    logic [ADDR_W:0]    start_sum;
    logic [PFN_W-1:0]   start_pfn;
    logic [PFN_W-1:0]   end_pfn;
    logic [PFN_W-1:0]   top_pfn;
    logic               p_live;
    logic               n_live;
    logic [LINK_W-1:0]  p_norm;
    logic [LINK_W-1:0]  n_norm;
    logic               desc_we;
    logic [IDX_W-1:0]   desc_wa;
    desc_t              desc_wd;
    logic               next_we;
    logic [IDX_W-1:0]   next_wa;
    logic [LINK_W-1:0]  next_wd;
    logic               prev_we;
    logic [IDX_W-1:0]   prev_wa;
    logic [LINK_W-1:0]  prev_wd;
    logic [IDX_W-1:0]   rd_addr;

    // A frame lies in the window when its offset from the base is below the size.
    function automatic logic in_win(input logic [PFN_W-1:0] x,
                                    input logic [PFN_W-1:0] b,
                                    input logic [CNT_W-1:0] w);
        logic [PFN_W-1:0] off;
        off = x - b;
        return (x >= b) && (off < PFN_W'(w));
    endfunction

    // Address arithmetic shared by the commands.
    always_comb
    begin
        win       = (pcount_reg > CNT_W'(NUM_PAGES)) ? CNT_W'(NUM_PAGES) : pcount_reg;
        base_ext  = PFN_W'(base_reg);
        cur_bit   = PFN_W'(1) << cur_reg;
        bud       = fpfn_reg ^ cur_bit;
        bud_off   = bud - base_ext;
        home_off  = fpfn_reg - base_ext;
        head_cur  = head_reg[cur_reg];
        half_sum  = (IDX_W+2)'(idx_reg) + ((IDX_W+2)'(1) << (cur_reg - ORD_W'(1)));
        ord_bit   = CNT_W'(1) << ord_reg;
        seed_bit  = PFN_W'(1) << ord_reg;
        start_sum = (ADDR_W+1)'(rstart_reg) + (ADDR_W+1)'((1 << PAGE_BITS) - 1);
        start_pfn = start_sum[ADDR_W:PAGE_BITS];
        end_pfn   = PFN_W'(rend_reg[ADDR_W-1:PAGE_BITS]);
        top_pfn   = base_ext + PFN_W'(win);
        p_live    = prev_q < NIL;
        n_live    = next_q < NIL;
        p_norm    = p_live ? prev_q : NIL;
        n_norm    = n_live ? next_q : NIL;
    end

    // Status toward the controller.
    always_comb
    begin
        flags.kind         = kind_reg;
        flags.order_bad    = ord_reg >= ORD_W'(ORDER_LEVELS);
        flags.frame_in_win = in_win(PFN_W'(frame_reg), base_ext, win);
        flags.head_hit     = head_cur < NIL;
        flags.cur_top      = cur_reg == ORD_W'(ORDER_LEVELS - 1);
        flags.split_more   = cur_reg > ord_reg;
        flags.half_ok      = half_sum < (IDX_W+2)'(NUM_PAGES);
        flags.chk_free     = desc_q.is_free;
        flags.can_merge    = ({1'b0, cur_reg} + 5'd1) < 5'(ORDER_LEVELS);
        flags.bud_in_win   = in_win(bud, base_ext, win);
        flags.bud_match    = desc_q.is_free && (desc_q.ord == cur_reg);
        flags.seed_more    = spfn_reg < limit_reg;
        flags.ord_shrink   = (ord_reg != '0)
                          && (((spfn_reg & (seed_bit - PFN_W'(1))) != '0)
                          || ((spfn_reg + seed_bit) > limit_reg));
        flags.clr_done     = clr_reg[IDX_W];
    end

    // Memory port control.
    always_comb
    begin
        desc_we = 1'b0;
        desc_wa = uidx_reg;
        desc_wd = '{is_free: 1'b0, ord: cur_reg};
        next_we = 1'b0;
        next_wa = uidx_reg;
        next_wd = head_cur;
        prev_we = 1'b0;
        prev_wa = uidx_reg;
        prev_wd = NIL;
        rd_addr = uidx_reg;
        unique case (cmd)
            CMD_CLEAR:
            begin
                desc_we = 1'b1;
                desc_wa = clr_reg[IDX_W-1:0];
                desc_wd = '0;
            end
            CMD_A_TAKE: rd_addr = head_cur[IDX_W-1:0];
            CMD_F_CHK:  rd_addr = home_off[IDX_W-1:0];
            CMD_F_BUD:  rd_addr = bud_off[IDX_W-1:0];
            CMD_A_UNLINK, CMD_F_MERGE:
            begin
                desc_we = 1'b1;
                next_we = p_live;
                next_wa = prev_q[IDX_W-1:0];
                next_wd = n_norm;
                prev_we = n_live;
                prev_wa = next_q[IDX_W-1:0];
                prev_wd = p_norm;
            end
            CMD_PUSH1:
            begin
                desc_we = 1'b1;
                desc_wd = '{is_free: 1'b1, ord: cur_reg};
                next_we = 1'b1;
                prev_we = 1'b1;
            end
            CMD_PUSH2:
            begin
                prev_we = h_reg < NIL;
                prev_wa = h_reg[IDX_W-1:0];
                prev_wd = LINK_W'(uidx_reg);
            end
            default:
            begin
            end
        endcase
    end

    // Memories with registered read data.
    always_ff @(posedge clk)
    begin
        if (desc_we)
        begin
            desc_mem[desc_wa] <= desc_wd;
        end
        desc_q <= desc_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (next_we)
        begin
            next_mem[next_wa] <= next_wd;
        end
        next_q <= next_mem[rd_addr];
    end

    always_ff @(posedge clk)
    begin
        if (prev_we)
        begin
            prev_mem[prev_wa] <= prev_wd;
        end
        prev_q <= prev_mem[rd_addr];
    end

    // Configuration, list heads, counters and the clearing pass.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            base_reg   <= '0;
            pcount_reg <= '0;
            total_reg  <= '0;
            clr_reg    <= '0;
            for (int i = 0; i < ORDER_LEVELS; i++)
            begin
                head_reg[i] <= NIL;
                cnt_reg[i]  <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                if (cfg_index == CFG_BASE)
                begin
                    base_reg <= cfg_data[FRAME_W-1:0];
                end
                else
                begin
                    pcount_reg <= cfg_data[CNT_W-1:0];
                end
            end
            unique case (cmd)
                CMD_CLEAR: clr_reg <= clr_reg + (IDX_W+1)'(1);
                CMD_A_UNLINK, CMD_F_MERGE:
                begin
                    if (!p_live)
                    begin
                        head_reg[cur_reg] <= n_norm;
                    end
                    cnt_reg[cur_reg] <= cnt_reg[cur_reg] - CNT_W'(1);
                    if (cmd == CMD_A_UNLINK)
                    begin
                        total_reg <= total_reg - ord_bit;
                    end
                end
                CMD_PUSH1:
                begin
                    head_reg[cur_reg] <= LINK_W'(uidx_reg);
                    cnt_reg[cur_reg]  <= cnt_reg[cur_reg] + CNT_W'(1);
                end
                CMD_F_HOME: total_reg <= total_reg + ord_bit;
                default:
                begin
                end
            endcase
        end
    end

    // Working registers of the item in progress.
    always_ff @(posedge clk)
    begin
        unique case (cmd)
            CMD_LOAD:
            begin
                kind_reg    <= kind;
                ord_reg     <= block_order;
                frame_reg   <= frame_number;
                rstart_reg  <= range_start_addr;
                rend_reg    <= range_end_addr;
                status_reg  <= ST_OK;
                granted_reg <= '0;
            end
            CMD_ST_ORDER: status_reg <= ST_BAD_ORDER;
            CMD_ST_NOBLK: status_reg <= ST_NO_BLOCK;
            CMD_ST_RANGE: status_reg <= ST_OUTSIDE;
            CMD_A_START:  cur_reg <= ord_reg;
            CMD_A_NEXT:   cur_reg <= cur_reg + ORD_W'(1);
            CMD_A_TAKE:
            begin
                idx_reg  <= head_cur[IDX_W-1:0];
                uidx_reg <= head_cur[IDX_W-1:0];
            end
            CMD_A_HALF:
            begin
                cur_reg  <= cur_reg - ORD_W'(1);
                uidx_reg <= half_sum[IDX_W-1:0];
            end
            CMD_PUSH1:   h_reg <= head_cur;
            CMD_A_GRANT: granted_reg <= base_reg + FRAME_W'(idx_reg);
            CMD_F_START:
            begin
                fpfn_reg <= PFN_W'(frame_reg);
                cur_reg  <= ord_reg;
            end
            CMD_F_BUD: uidx_reg <= bud_off[IDX_W-1:0];
            CMD_F_MERGE:
            begin
                fpfn_reg <= fpfn_reg & ~cur_bit;
                cur_reg  <= cur_reg + ORD_W'(1);
            end
            CMD_F_HOME: uidx_reg <= home_off[IDX_W-1:0];
            CMD_S_INIT:
            begin
                spfn_reg  <= (start_pfn < base_ext) ? base_ext : start_pfn;
                limit_reg <= (end_pfn > top_pfn) ? top_pfn : end_pfn;
            end
            CMD_S_TOP:  ord_reg <= ORD_W'(ORDER_LEVELS - 1);
            CMD_S_DOWN: ord_reg <= ord_reg - ORD_W'(1);
            CMD_S_FREE:
            begin
                fpfn_reg <= spfn_reg;
                cur_reg  <= ord_reg;
            end
            CMD_S_STEP: spfn_reg <= spfn_reg + seed_bit;
            CMD_OUT:
            begin
                out_status_reg  <= status_reg;
                out_granted_reg <= granted_reg;
                out_free_reg    <= total_reg;
            end
            default:
            begin
            end
        endcase
    end

    assign status        = out_status_reg;
    assign granted_frame = out_granted_reg;
    assign pages_free    = out_free_reg;

endmodule

FILE: sv/bpa_ctrl.sv
// ----------------------------------------------------------------------------
// bpa_ctrl
// Sequencer that steps the datapath through alloc, free and seed operations.
// ----------------------------------------------------------------------------
module bpa_ctrl import bpa_pkg::*; (
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    input  logic      out_stall,
    input  dp_flags_t flags,
    output cmd_t      cmd,
    output logic      in_stall,
    output logic      out_valid
);

    typedef enum logic [4:0] {
        S_CLEAR,
        S_IDLE,
        S_DISPATCH,
        S_A_SCAN,
        S_A_UNLINK,
        S_A_SPLIT,
        S_PUSH1,
        S_PUSH2,
        S_F_CHK,
        S_F_CHKW,
        S_F_BUD,
        S_F_BUDW,
        S_F_END,
        S_S_LOOP,
        S_S_ORD,
        S_DONE
    } state_t;

    state_t state_reg, state_next;
    logic   out_valid_reg, out_valid_next;

    // Next state and the command for this cycle.
    always_comb
    begin
        state_next     = state_reg;
        cmd            = CMD_IDLE;
        out_valid_next = out_valid_reg & out_stall;
        unique case (state_reg)
            S_CLEAR:
            begin
                if (flags.clr_done)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd = CMD_CLEAR;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd        = CMD_LOAD;
                    state_next = S_DISPATCH;
                end
            end
            S_DISPATCH:
            begin
                priority if (flags.kind == KIND_ALLOC)
                begin
                    if (flags.order_bad)
                    begin
                        cmd        = CMD_ST_ORDER;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd        = CMD_A_START;
                        state_next = S_A_SCAN;
                    end
                end
                else if (flags.kind == KIND_FREE)
                begin
                    priority if (flags.order_bad)
                    begin
                        cmd        = CMD_ST_ORDER;
                        state_next = S_DONE;
                    end
                    else if (!flags.frame_in_win)
                    begin
                        cmd        = CMD_ST_RANGE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        cmd        = CMD_F_START;
                        state_next = S_F_CHK;
                    end
                end
                else if (flags.kind == KIND_SEED)
                begin
                    cmd        = CMD_S_INIT;
                    state_next = S_S_LOOP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            // Alloc: find the smallest non-empty order at or above the request, take its head.
            S_A_SCAN:
            begin
                priority if (flags.head_hit)
                begin
                    cmd        = CMD_A_TAKE;
                    state_next = S_A_UNLINK;
                end
                else if (flags.cur_top)
                begin
                    cmd        = CMD_ST_NOBLK;
                    state_next = S_DONE;
                end
                else
                begin
                    cmd = CMD_A_NEXT;
                end
            end
            S_A_UNLINK:
            begin
                cmd        = CMD_A_UNLINK;
                state_next = S_A_SPLIT;
            end
            // Return upper halves to the lower orders.
            S_A_SPLIT:
            begin
                if (flags.split_more)
                begin
                    cmd        = CMD_A_HALF;
                    state_next = flags.half_ok ? S_PUSH1 : S_A_SPLIT;
                end
                else
                begin
                    cmd        = CMD_A_GRANT;
                    state_next = S_DONE;
                end
            end
            S_PUSH1:
            begin
                cmd        = CMD_PUSH1;
                state_next = S_PUSH2;
            end
            S_PUSH2:
            begin
                cmd        = CMD_PUSH2;
                state_next = (flags.kind == KIND_ALLOC) ? S_A_SPLIT : S_F_END;
            end
            // Free: skip a block that is already free, then merge upward.
            S_F_CHK:
            begin
                cmd        = CMD_F_CHK;
                state_next = S_F_CHKW;
            end
            S_F_CHKW:
            begin
                state_next = flags.chk_free ? S_F_END : S_F_BUD;
            end
            S_F_BUD:
            begin
                if (flags.can_merge && flags.bud_in_win)
                begin
                    cmd        = CMD_F_BUD;
                    state_next = S_F_BUDW;
                end
                else
                begin
                    cmd        = CMD_F_HOME;
                    state_next = S_PUSH1;
                end
            end
            S_F_BUDW:
            begin
                if (flags.bud_match)
                begin
                    cmd        = CMD_F_MERGE;
                    state_next = S_F_BUD;
                end
                else
                begin
                    cmd        = CMD_F_HOME;
                    state_next = S_PUSH1;
                end
            end
            S_F_END:
            begin
                if (flags.kind == KIND_SEED)
                begin
                    cmd        = CMD_S_STEP;
                    state_next = S_S_LOOP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            // Seed: carve the range into its largest aligned blocks.
            S_S_LOOP:
            begin
                if (flags.seed_more)
                begin
                    cmd        = CMD_S_TOP;
                    state_next = S_S_ORD;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_S_ORD:
            begin
                if (flags.ord_shrink)
                begin
                    cmd = CMD_S_DOWN;
                end
                else
                begin
                    cmd        = CMD_S_FREE;
                    state_next = S_F_CHK;
                end
            end
            // Hand the result to the output register once it is free.
            S_DONE:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    cmd            = CMD_OUT;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State and registered outputs.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

    assign in_stall  = (state_reg != S_IDLE);
    assign out_valid = out_valid_reg;

endmodule

FILE: sv/bpa_checker.sv
// ----------------------------------------------------------------------------
// bpa_checker
// Port-level checks of the buddy page allocator, bound to the top level.
// ----------------------------------------------------------------------------
module bpa_checker import bpa_pkg::*; (
    input logic               clk,
    input logic               rst_n,
    input logic               in_valid,
    input logic               in_stall,
    input logic               out_valid,
    input logic               out_stall,
    input logic [1:0]         status,
    input logic [FRAME_W-1:0] granted_frame,
    input logic [CNT_W-1:0]   pages_free
);

    // The block works on one item at a time.
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall |=> in_stall)
        else $error("item accepted while the previous one is in progress");

    // Only a successful operation reports a granted frame.
    a_grant_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (status != ST_OK) |-> granted_frame == '0)
        else $error("granted frame set on a failed operation");

    // A stalled result stays offered.
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid)
        else $error("result withdrawn while stalled");

    // A stalled result keeps its payload.
    a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> $stable(status) && $stable(granted_frame)
                                   && $stable(pages_free))
        else $error("result changed while stalled");

endmodule

bind buddy_page_allocator bpa_checker u_bpa_checker (.*);
